// ===== sv/largest_gap_extent_allocator_core_macros.svh =====
// Assertion macros shared by the checker of the extent allocator.
`ifndef LARGEST_GAP_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define LARGEST_GAP_EXTENT_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define LGEA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("extent allocator check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LGEA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("extent allocator check failed");

`endif

// ===== sv/lgea_pkg.sv =====
// Shared types and constants of the largest gap extent allocator.
`default_nettype none
package lgea_pkg;

   localparam int LBA_W = 64;
   localparam int ALIGN_W = 17;
   localparam int COUNT_W = 8;
   localparam int SLOT_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int DEF_TABLE_ENTRIES = 128;

   localparam logic [LBA_W-1:0] TOP_LBA = '1;
   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 8'd128;
   localparam logic [ALIGN_W-1:0] ALIGN_RESET = 17'd64;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LBA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_LBA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN = 2'd3;

   // Request kinds carried in tuser.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_ALLOC = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_NO_SLOT,
      STATUS_NO_GAP,
      STATUS_ALIGN_EMPTY,
      STATUS_TOO_SMALL
   } status_type;

   // Control of the sorting chain, common to every cell.
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/largest_gap_extent_allocator_core.sv =====
// Top level of the largest gap extent allocator.
//
// Requests enter on req_*: tuser 0 writes one table entry, tuser 1 asks for an
// allocation. A write gives no response. An allocation gives one response on
// rsp_* carrying status, slot and the placed extent. An allocation reads the
// live entries, lets the sorting chain settle, walks the sorted entries from
// the head, runs the 64-step alignment remainder and closes with the rounding,
// check, table write and response steps. One allocation is worked on at a time.
// Configuration writes on csr_* are always taken and apply at once; they are
// to be made only while no allocation is under way.
// A finished response waits in the output register while rsp_tready is low;
// requests are still taken meanwhile, but a further allocation holds in its
// closing step until the register empties. Reset clears the table to all zero
// through per-entry valid bits and loads the register reset values.
`default_nettype none
module largest_gap_extent_allocator_core #(
   parameter int TABLE_ENTRIES = lgea_pkg::DEF_TABLE_ENTRIES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // entry_index[6:0], entry_first[70:7], entry_last[134:71],
   // entry_in_use[135], request_sectors[199:136]
   input  wire logic [199:0]                      req_tdata,
   // action[0]
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status[2:0], slot[9:3], alloc_first[73:10], alloc_last[137:74], zero fill
   output logic      [143:0]                      rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lgea_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lgea_pkg::LBA_W-1:0]        csr_data
);
   import lgea_pkg::*;

   localparam int N = TABLE_ENTRIES;
   localparam int AW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = $clog2(N + 1);
   localparam int RW = 2 * LBA_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_DRAIN, ST_PROC, ST_LAST, ST_GAP,
      ST_MODGO, ST_MOD, ST_ALIGN, ST_CHECK, ST_WRITE, ST_OUT
   } state_type;

   state_type            state_ff;

   // Configuration registers.
   logic [LBA_W-1:0]     first_ff, last_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [ALIGN_W-1:0]   align_ff;

   // Request fields.
   logic                 f_action, f_in_use;
   logic [SLOT_W-1:0]    f_index;
   logic [LBA_W-1:0]     f_first, f_last, f_req;
   logic                 req_fire, idx_ok;

   // Table storage.
   logic [N-1:0]         valid_ff;
   logic                 vld_rd_ff;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [RW-1:0]        ram_wdata, ram_rdata;

   // Allocation working registers.
   logic [CW-1:0]        cnt_ff, rd_cnt_ff, drn_ff;
   logic                 pend_ff;
   logic [AW-1:0]        pidx_ff, slot_ff;
   logic                 found_ff;
   logic [LBA_W-1:0]     req_ff, bs_ff, best_bs_ff, best_len_ff, gs_ff, ge_ff;
   logic                 bs_top_ff, any_ff;
   status_type           status_ff;
   logic                 rsp_valid_ff;
   logic [143:0]         rsp_data_ff;
   logic [143:0]         rsp_word;

   // Chain signals.
   cell_ctrl_type        ctrl;
   logic                 feed_v;
   logic [LBA_W-1:0]     e_start, e_end;
   logic                 e_used;
   logic [N-1:0]         fwd_v, held_v;
   logic [LBA_W-1:0]     fwd_k [N];
   logic [LBA_W-1:0]     fwd_l [N];
   logic [AW-1:0]        fwd_i [N];
   logic [LBA_W-1:0]     held_k [N];
   logic [LBA_W-1:0]     held_l [N];
   logic [AW-1:0]        held_i [N];

   // Arithmetic helpers.
   logic [CW-1:0]        live_cnt;
   logic [LBA_W-1:0]     diff, tail_len;
   logic [ALIGN_W-1:0]   al_eff, mod_rem;
   logic                 mod_done;
   logic [LBA_W:0]       align_sum, size;

   // Request unpacking.
   assign f_index = req_tdata[6:0];
   assign f_first = req_tdata[70:7];
   assign f_last = req_tdata[134:71];
   assign f_in_use = req_tdata[135];
   assign f_req = req_tdata[199:136];
   assign f_action = req_tuser;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign idx_ok = 32'(f_index) < N;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign live_cnt = (32'(count_ff) > N) ? CW'(N) : CW'(count_ff);
   assign al_eff = (align_ff == '0) ? ALIGN_W'(1) : align_ff;

   // Table writes: host writes when idle, allocation result when closing.
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = AW'(f_index);
      ram_wdata = {f_in_use, f_last, f_first};
      if (state_ff == ST_WRITE) begin
         ram_we = 1'b1;
         ram_waddr = slot_ff;
         ram_wdata = (status_ff == STATUS_OK) ? {1'b1, ge_ff, gs_ff} : '0;
      end else if (req_fire && f_action == ACTION_WRITE && idx_ok) begin
         ram_we = 1'b1;
      end
   end
   assign ram_raddr = rd_cnt_ff[AW-1:0];

   lgea_ram #(.WIDTH(RW), .DEPTH(N), .AW(AW)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   // Entry read back; a never written entry reads as zero.
   assign e_start = vld_rd_ff ? ram_rdata[LBA_W-1:0] : '0;
   assign e_end = vld_rd_ff ? ram_rdata[2*LBA_W-1:LBA_W] : '0;
   assign e_used = vld_rd_ff && ram_rdata[RW-1];
   assign feed_v = pend_ff && (e_start >= first_ff);

   assign ctrl.clear = req_fire && (f_action == ACTION_ALLOC);
   assign ctrl.shift = (state_ff == ST_PROC) && held_v[0];

   // Sorting chain.
   for (genvar k = 0; k < N; k++) begin : g_cell
      logic             c_in_v, c_nx_v;
      logic [LBA_W-1:0] c_in_k, c_in_l, c_nx_k, c_nx_l;
      logic [AW-1:0]    c_in_i, c_nx_i;
      if (k == 0) begin : g_head
         assign c_in_v = feed_v;
         assign c_in_k = e_start;
         assign c_in_l = e_end;
         assign c_in_i = pidx_ff;
      end else begin : g_body
         assign c_in_v = fwd_v[k-1];
         assign c_in_k = fwd_k[k-1];
         assign c_in_l = fwd_l[k-1];
         assign c_in_i = fwd_i[k-1];
      end
      if (k == N - 1) begin : g_tail
         assign c_nx_v = 1'b0;
         assign c_nx_k = '0;
         assign c_nx_l = '0;
         assign c_nx_i = '0;
      end else begin : g_link
         assign c_nx_v = held_v[k+1];
         assign c_nx_k = held_k[k+1];
         assign c_nx_l = held_l[k+1];
         assign c_nx_i = held_i[k+1];
      end
      lgea_cell #(.IDX_W(AW)) u_cell (
         .clock(clock), .reset(reset), .ctrl(ctrl),
         .in_valid(c_in_v), .in_key(c_in_k), .in_idx(c_in_i), .in_last(c_in_l),
         .nxt_valid(c_nx_v), .nxt_key(c_nx_k), .nxt_idx(c_nx_i), .nxt_last(c_nx_l),
         .fwd_valid(fwd_v[k]), .fwd_key(fwd_k[k]), .fwd_idx(fwd_i[k]),
         .fwd_last(fwd_l[k]),
         .held_valid(held_v[k]), .held_key(held_k[k]), .held_idx(held_i[k]),
         .held_last(held_l[k])
      );
   end

   lgea_mod u_mod (
      .clock(clock), .reset(reset), .start(state_ff == ST_MODGO),
      .dividend(gs_ff), .divisor(al_eff), .done(mod_done), .remainder(mod_rem)
   );

   // Gap arithmetic.
   assign diff = held_k[0] - bs_ff;
   assign tail_len = (last_ff == TOP_LBA) ? (LBA_W'(0) - bs_ff) :
                     (bs_ff <= last_ff) ? (last_ff - bs_ff + 1'b1) : '0;
   assign align_sum = {1'b0, gs_ff} + (LBA_W + 1)'(al_eff - mod_rem);
   assign size = {1'b0, ge_ff} - {1'b0, gs_ff} + 1'b1;

   // Response word; failures carry no extent.
   always_comb begin
      rsp_word = '0;
      rsp_word[2:0] = status_ff;
      if (status_ff != STATUS_NO_SLOT) begin
         rsp_word[9:3] = SLOT_W'(slot_ff);
      end
      if (status_ff == STATUS_OK) begin
         rsp_word[73:10] = gs_ff;
         rsp_word[137:74] = ge_ff;
      end
   end

   // Sequencer and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= '0;
         last_ff <= '0;
         count_ff <= ENTRY_COUNT_RESET;
         align_ff <= ALIGN_RESET;
         valid_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FIRST_LBA: first_ff <= csr_data;
               CSR_LAST_LBA: last_ff <= csr_data;
               CSR_ENTRY_COUNT: count_ff <= csr_data[COUNT_W-1:0];
               CSR_ALIGN: align_ff <= csr_data[ALIGN_W-1:0];
               default: ;
            endcase
         end
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         vld_rd_ff <= valid_ff[ram_raddr];
         pend_ff <= (state_ff == ST_LOAD) && (rd_cnt_ff < cnt_ff);

         case (state_ff)
            ST_IDLE: begin
               if (req_fire && f_action == ACTION_ALLOC) begin
                  req_ff <= f_req;
                  cnt_ff <= live_cnt;
                  rd_cnt_ff <= '0;
                  found_ff <= 1'b0;
                  slot_ff <= '0;
                  bs_ff <= first_ff;
                  best_bs_ff <= first_ff;
                  best_len_ff <= '0;
                  bs_top_ff <= 1'b0;
                  any_ff <= 1'b0;
                  status_ff <= STATUS_OK;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               if (rd_cnt_ff < cnt_ff) begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
                  pidx_ff <= rd_cnt_ff[AW-1:0];
               end
               // Lowest unused slot.
               if (pend_ff && !found_ff && !e_used) begin
                  found_ff <= 1'b1;
                  slot_ff <= pidx_ff;
               end
               if (rd_cnt_ff == cnt_ff && !pend_ff) begin
                  drn_ff <= '0;
                  if (found_ff) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     status_ff <= STATUS_NO_SLOT;
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_DRAIN: begin
               drn_ff <= drn_ff + 1'b1;
               if (drn_ff == CW'(N - 1)) begin
                  state_ff <= ST_PROC;
               end
            end
            ST_PROC: begin
               // One sorted entry a cycle from the head of the chain.
               if (held_v[0]) begin
                  any_ff <= 1'b1;
                  if (!bs_top_ff && bs_ff < held_k[0] && diff > best_len_ff) begin
                     best_len_ff <= diff;
                     best_bs_ff <= bs_ff;
                  end
                  if (held_l[0] == TOP_LBA) begin
                     bs_top_ff <= 1'b1;
                  end else begin
                     bs_ff <= held_l[0] + 1'b1;
                     bs_top_ff <= 1'b0;
                  end
               end else begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               if (!any_ff) begin
                  if (first_ff > last_ff) begin
                     status_ff <= STATUS_NO_GAP;
                     state_ff <= ST_WRITE;
                  end else begin
                     gs_ff <= first_ff;
                     ge_ff <= last_ff;
                     state_ff <= ST_MODGO;
                  end
               end else begin
                  if (!bs_top_ff && tail_len > best_len_ff) begin
                     best_len_ff <= tail_len;
                     best_bs_ff <= bs_ff;
                  end
                  state_ff <= ST_GAP;
               end
            end
            ST_GAP: begin
               if (best_len_ff == '0) begin
                  status_ff <= STATUS_NO_GAP;
                  state_ff <= ST_WRITE;
               end else begin
                  gs_ff <= best_bs_ff;
                  ge_ff <= best_bs_ff + (best_len_ff - 1'b1);
                  state_ff <= ST_MODGO;
               end
            end
            ST_MODGO: begin
               state_ff <= ST_MOD;
            end
            ST_MOD: begin
               if (mod_done) begin
                  state_ff <= ST_ALIGN;
               end
            end
            ST_ALIGN: begin
               // Round the start up; running past the top address fails.
               if (mod_rem != '0 && align_sum[LBA_W]) begin
                  status_ff <= STATUS_ALIGN_EMPTY;
                  state_ff <= ST_WRITE;
               end else begin
                  if (mod_rem != '0) begin
                     gs_ff <= align_sum[LBA_W-1:0];
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               state_ff <= ST_WRITE;
               if (gs_ff >= ge_ff) begin
                  status_ff <= STATUS_ALIGN_EMPTY;
               end else if (req_ff != '0) begin
                  // A gap spanning the whole address space never counts as too small.
                  if (!(gs_ff == '0 && ge_ff == TOP_LBA) && {1'b0, req_ff} > size) begin
                     status_ff <= STATUS_TOO_SMALL;
                  end else if ((gs_ff == '0 && ge_ff == TOP_LBA) || {1'b0, req_ff} < size)
                  begin
                     ge_ff <= gs_ff + (req_ff - 1'b1);
                  end
               end
            end
            ST_WRITE: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= rsp_word;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== sv/lgea_ram.sv =====
// Generic single write port RAM with a registered read port.
`default_nettype none
module lgea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== sv/lgea_cell.sv =====
// One cell of the systolic sorting chain: keeps the smallest key seen.
`default_nettype none
module lgea_cell #(
   parameter int IDX_W = 7
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lgea_pkg::cell_ctrl_type      ctrl,
   input  wire logic                         in_valid,
   input  wire logic [lgea_pkg::LBA_W-1:0]   in_key,
   input  wire logic [IDX_W-1:0]             in_idx,
   input  wire logic [lgea_pkg::LBA_W-1:0]   in_last,
   input  wire logic                         nxt_valid,
   input  wire logic [lgea_pkg::LBA_W-1:0]   nxt_key,
   input  wire logic [IDX_W-1:0]             nxt_idx,
   input  wire logic [lgea_pkg::LBA_W-1:0]   nxt_last,
   output logic                              fwd_valid,
   output logic      [lgea_pkg::LBA_W-1:0]   fwd_key,
   output logic      [IDX_W-1:0]             fwd_idx,
   output logic      [lgea_pkg::LBA_W-1:0]   fwd_last,
   output logic                              held_valid,
   output logic      [lgea_pkg::LBA_W-1:0]   held_key,
   output logic      [IDX_W-1:0]             held_idx,
   output logic      [lgea_pkg::LBA_W-1:0]   held_last
);
   import lgea_pkg::*;

   logic in_smaller;

   // Order by start, then by slot index, so every key is distinct.
   assign in_smaller = {in_key, in_idx} < {held_key, held_idx};

   // Insert keeps the smaller item and passes the other on; shift moves towards the head.
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         held_valid <= 1'b0;
         fwd_valid <= 1'b0;
      end else if (ctrl.shift) begin
         held_valid <= nxt_valid;
         held_key <= nxt_key;
         held_idx <= nxt_idx;
         held_last <= nxt_last;
         fwd_valid <= 1'b0;
      end else if (!in_valid) begin
         fwd_valid <= 1'b0;
      end else if (!held_valid) begin
         held_valid <= 1'b1;
         held_key <= in_key;
         held_idx <= in_idx;
         held_last <= in_last;
         fwd_valid <= 1'b0;
      end else if (in_smaller) begin
         fwd_valid <= 1'b1;
         fwd_key <= held_key;
         fwd_idx <= held_idx;
         fwd_last <= held_last;
         held_key <= in_key;
         held_idx <= in_idx;
         held_last <= in_last;
      end else begin
         fwd_valid <= 1'b1;
         fwd_key <= in_key;
         fwd_idx <= in_idx;
         fwd_last <= in_last;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lgea_mod.sv =====
// Bit-serial remainder unit: one dividend bit per cycle.
`default_nettype none
module lgea_mod (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [lgea_pkg::LBA_W-1:0]     dividend,
   input  wire logic [lgea_pkg::ALIGN_W-1:0]   divisor,
   output logic                                done,
   output logic      [lgea_pkg::ALIGN_W-1:0]   remainder
);
   import lgea_pkg::*;

   localparam int STEP_W = $clog2(LBA_W);

   logic                 busy_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [LBA_W-1:0]     dvd_ff;
   logic [ALIGN_W-1:0]   rem_ff;
   logic [ALIGN_W-1:0]   div_ff;
   logic [ALIGN_W:0]     trial;
   logic [ALIGN_W:0]     rem_in;

   // Shift in the next dividend bit and subtract once where it fits.
   always_comb begin
      trial = {rem_ff, dvd_ff[LBA_W-1]};
      rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done <= 1'b0;
      end else begin
         done <= !start && busy_ff && (step_ff == STEP_W'(LBA_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            dvd_ff <= dividend;
            div_ff <= divisor;
            rem_ff <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in[ALIGN_W-1:0];
            dvd_ff <= {dvd_ff[LBA_W-2:0], 1'b0};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(LBA_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== sv/lgea_checker.sv =====
// Port-level checker for the extent allocator, bound to the top level.
`default_nettype none
`include "largest_gap_extent_allocator_core_macros.svh"
module lgea_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [143:0]                      rsp_tdata
);
   import lgea_pkg::*;

   // A stalled response holds its value.
   `LGEA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // An allocation request occupies the block for the next cycle.
   `LGEA_ASSERT_NEXT(a_alloc_busy, req_tvalid && req_tready && req_tuser == ACTION_ALLOC,
      !req_tready)

   // After a table write the block is ready again in the next cycle.
   `LGEA_ASSERT_NEXT(a_write_quick, req_tvalid && req_tready && req_tuser == ACTION_WRITE,
      req_tready)

   // A failed allocation reports no extent.
   `LGEA_ASSERT_NOW(a_fail_zero, rsp_tvalid && rsp_tdata[2:0] != STATUS_OK,
      rsp_tdata[137:10] == '0)

endmodule

bind largest_gap_extent_allocator_core lgea_checker u_lgea_checker (.*);
`default_nettype wire

// ===== tb/sv/largest_gap_extent_allocator_core_tb.sv =====
// Testbench of the largest gap extent allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module largest_gap_extent_allocator_core_tb;
   import lgea_pkg::*;

   localparam int NSLOT = 128;
   localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        action;
      logic [6:0]  idx;
      logic [63:0] first;
      logic [63:0] last;
      logic        in_use;
      logic [63:0] sectors;
   } request_type;

   typedef struct packed {
      status_type  status;
      logic [6:0]  slot;
      logic [63:0] first;
      logic [63:0] last;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [199:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   request_type pending_requests[$];
   placement_type expected_placements[$];
   int error_count = 0;
   int req_wait = 0;
   int rsp_wait = 0;

   // Predictor state.
   logic [63:0] p_first_lba, p_last_lba;
   logic [7:0] p_count;
   logic [16:0] p_align;
   logic [63:0] p_start[NSLOT];
   logic [63:0] p_end[NSLOT];
   logic p_used[NSLOT];

   largest_gap_extent_allocator_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // Largest gap search over the listed entries in (start, index) order.
   function automatic bit largest_gap(input int cnt, output logic [63:0] gs,
                                      output logic [63:0] ge);
      logic [63:0] bs, best_bs, best_len, pkey, k, pk, len;
      bit bs_top, any, have_prev;
      int pidx, pick;
      bs = p_first_lba; best_bs = p_first_lba; best_len = 0;
      bs_top = 0; any = 0; have_prev = 0; pkey = 0; pidx = 0;
      gs = 0; ge = 0;
      forever begin
         pick = -1; pk = 0;
         for (int i = 0; i < cnt; i++) begin
            k = p_start[i];
            if (k < p_first_lba) continue;
            if (have_prev && (k < pkey || (k == pkey && i <= pidx))) continue;
            if (pick < 0 || k < pk) begin
               pick = i; pk = k;
            end
         end
         if (pick < 0) break;
         any = 1;
         if (!bs_top && bs < pk && pk - bs > best_len) begin
            best_len = pk - bs; best_bs = bs;
         end
         if (p_end[pick] == TOP) bs_top = 1;
         else begin
            bs = p_end[pick] + 1; bs_top = 0;
         end
         have_prev = 1; pkey = pk; pidx = pick;
      end
      if (!any) begin
         if (p_first_lba > p_last_lba) return 0;
         gs = p_first_lba; ge = p_last_lba;
         return 1;
      end
      if (!bs_top) begin
         len = 0;
         if (p_last_lba == TOP) len = 64'd0 - bs;
         else if (bs < p_last_lba + 1) len = p_last_lba + 1 - bs;
         if (len > best_len) begin
            best_len = len; best_bs = bs;
         end
      end
      if (best_len == 0) return 0;
      gs = best_bs; ge = best_bs + (best_len - 1);
      return 1;
   endfunction

   // Apply one request to the predictor; queue a placement for allocations.
   function automatic void predict_placement(input request_type r);
      placement_type res;
      int cnt, slot;
      logic [63:0] gs, ge, al, rem, size;
      bit full;
      if (r.action == ACTION_WRITE) begin
         p_start[r.idx] = r.first; p_end[r.idx] = r.last; p_used[r.idx] = r.in_use;
         return;
      end
      cnt = (p_count > NSLOT) ? NSLOT : int'(p_count);
      for (slot = 0; slot < cnt; slot++) if (!p_used[slot]) break;
      res = '0;
      if (slot == cnt) begin
         res.status = STATUS_NO_SLOT;
         expected_placements.push_back(res);
         return;
      end
      res.slot = slot[6:0];
      al = (p_align == 0) ? 64'd1 : 64'(p_align);
      res.status = STATUS_OK;
      if (!largest_gap(cnt, gs, ge)) res.status = STATUS_NO_GAP;
      else begin
         rem = gs % al;
         if (rem != 0) begin
            if (gs > TOP - (al - rem)) res.status = STATUS_ALIGN_EMPTY;
            else gs += al - rem;
         end
         if (res.status == STATUS_OK && gs >= ge) res.status = STATUS_ALIGN_EMPTY;
         if (res.status == STATUS_OK && r.sectors != 0) begin
            full = (gs == 0 && ge == TOP);
            size = ge - gs + 1;
            if (!full && r.sectors > size) res.status = STATUS_TOO_SMALL;
            else if (full || r.sectors < size) ge = gs + (r.sectors - 1);
         end
      end
      if (res.status != STATUS_OK) begin
         p_start[slot] = 0; p_end[slot] = 0;
      end else begin
         p_start[slot] = gs; p_end[slot] = ge; p_used[slot] = 1;
         res.first = gs; res.last = ge;
      end
      expected_placements.push_back(res);
   endfunction

   // Driver: presents queued requests with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // hold the current request
      end else if (req_wait > 0) begin
         req_wait <= req_wait - 1;
         req_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
         request_type r;
         r = pending_requests.pop_front();
         predict_placement(r);
         req_tvalid <= 1'b1;
         req_tuser <= r.action;
         req_tdata <= {r.sectors, r.in_use, r.last, r.first, r.idx};
         req_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Monitor: random back-pressure and field checks on responses.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            placement_type want;
            if (expected_placements.size() == 0) begin
               report("unexpected response", rsp_tdata[63:0], 64'd0);
            end else begin
               want = expected_placements.pop_front();
               if (rsp_tdata[2:0] != want.status) report("status", rsp_tdata[2:0], want.status);
               if (rsp_tdata[9:3] != want.slot) report("slot", rsp_tdata[9:3], want.slot);
               if (rsp_tdata[73:10] != want.first) report("first", rsp_tdata[73:10], want.first);
               if (rsp_tdata[137:74] != want.last) report("last", rsp_tdata[137:74], want.last);
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One register write; the channel is released on the following edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [63:0] value);
      csr_valid <= 1'b1; csr_index <= index; csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_FIRST_LBA: p_first_lba = value;
         CSR_LAST_LBA: p_last_lba = value;
         CSR_ENTRY_COUNT: p_count = value[7:0];
         default: p_align = value[16:0];
      endcase
   endtask

   // Wait for the queues to drain and the block to fall idle.
   task automatic drain();
      while (pending_requests.size() > 0 || req_tvalid || expected_placements.size() > 0)
         @(posedge clock);
      repeat (450) @(posedge clock);
   endtask

   function automatic request_type entry_write(input logic [6:0] i, input logic [63:0] f,
                                               input logic [63:0] l, input logic u);
      request_type r;
      r = '0;
      r.action = ACTION_WRITE; r.idx = i; r.first = f; r.last = l; r.in_use = u;
      r.sectors = {$urandom, $urandom};
      return r;
   endfunction

   function automatic request_type alloc_req(input logic [63:0] s);
      request_type r;
      r = '0;
      r.action = ACTION_ALLOC; r.sectors = s;
      r.idx = 7'($urandom); r.first = {$urandom, $urandom}; r.last = {$urandom, $urandom};
      r.in_use = 1'($urandom);
      return r;
   endfunction

   function automatic logic [63:0] rand_addr(input logic [63:0] base, input int span);
      case ($urandom_range(0, 5))
         0: return TOP - $urandom_range(0, span);
         1: return {$urandom, $urandom};
         default: return base + $urandom_range(0, span);
      endcase
   endfunction

   initial begin
      logic [63:0] base, f;
      int span;
      p_first_lba = 0; p_last_lba = 0; p_count = ENTRY_COUNT_RESET; p_align = ALIGN_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         p_start[i] = 0; p_end[i] = 0; p_used[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, whole range, wrap edges and failures.
      pending_requests.push_back(alloc_req(64'd0));
      drain();
      write_reg(CSR_FIRST_LBA, 64'd0);
      write_reg(CSR_LAST_LBA, TOP);
      write_reg(CSR_ENTRY_COUNT, 64'd8);
      write_reg(CSR_ALIGN, 64'd1);
      for (int i = 0; i < 8; i++)
         pending_requests.push_back(entry_write(7'(i), 64'd0, 64'd0, 1'b0));
      pending_requests.push_back(alloc_req(64'd0));
      pending_requests.push_back(alloc_req(TOP));
      pending_requests.push_back(entry_write(7'd0, TOP - 64'd10, TOP, 1'b1));
      pending_requests.push_back(alloc_req(TOP));
      pending_requests.push_back(alloc_req(64'd100));
      pending_requests.push_back(entry_write(7'd127, 64'd5, 64'd6, 1'b1));
      pending_requests.push_back(alloc_req(64'd1));
      drain();
      write_reg(CSR_ALIGN, 64'd0);
      write_reg(CSR_FIRST_LBA, TOP - 64'd2);
      write_reg(CSR_ENTRY_COUNT, 64'd255);
      pending_requests.push_back(alloc_req(64'd0));
      drain();
      write_reg(CSR_ALIGN, 64'd65536);
      write_reg(CSR_FIRST_LBA, TOP - 64'd5);
      pending_requests.push_back(alloc_req(64'd0));
      drain();
      write_reg(CSR_FIRST_LBA, 64'd10);
      write_reg(CSR_LAST_LBA, 64'd5);
      pending_requests.push_back(alloc_req(64'd0));
      drain();
      write_reg(CSR_ENTRY_COUNT, 64'd0);
      pending_requests.push_back(alloc_req(64'd3));
      drain();

      // Random phases with fresh settings; mostly small tables for speed.
      for (int ph = 0; ph < 12; ph++) begin
         base = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : $urandom_range(0, 4000);
         span = $urandom_range(200, 20000);
         write_reg(CSR_FIRST_LBA, base);
         write_reg(CSR_LAST_LBA, ($urandom_range(0, 4) == 0) ? TOP
                   : (($urandom_range(0, 6) == 0) ? base - 1 : base + span));
         write_reg(CSR_ENTRY_COUNT, 64'((ph == 5) ? 8'd128 : (ph == 9) ? 8'd200
                   : 8'($urandom_range(1, 16))));
         write_reg(CSR_ALIGN, 64'((ph == 3) ? 17'd65536 : (ph == 4) ? 17'd0
                   : 17'(1 << $urandom_range(0, 8)) + 17'($urandom_range(0, 1))));
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 2) == 0) begin
               f = rand_addr(base, span);
               pending_requests.push_back(entry_write($urandom_range(0, 20) == 0 ?
                  7'($urandom) : 7'($urandom_range(0, 17)), f,
                  ($urandom_range(0, 5) == 0) ? TOP : f + $urandom_range(0, 300),
                  $urandom_range(0, 3) == 0));
            end else begin
               case ($urandom_range(0, 4))
                  0: pending_requests.push_back(alloc_req(64'd0));
                  1: pending_requests.push_back(alloc_req({$urandom, $urandom}));
                  default: pending_requests.push_back(alloc_req(64'($urandom_range(1, 400))));
               endcase
            end
         end
         drain();
      end

      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
